// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL modules of the sentence checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, and held off while rst_n is low.
`define NSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, during reset too.
`define NSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/nsc_pkg.sv -----
// Package with the constants, types and helper functions of the sentence checker.
`timescale 1ns / 1ps

package nsc_pkg;

  // Default configuration of the top level.
  localparam int TAG_CHARS_DEF   = 5;
  localparam int COMMA_LIMIT_DEF = 15;

  // Configuration port layout: 64-bit data, one register slot every 8 bytes.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_SLOT_LSB = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_SLOT_LSB;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TAG = '0;

  // Reset value of the tag register: "GPRMC", first character in the top used byte.
  localparam logic [63:0] TAG_RESET = 64'h0000_0047_5052_4D43;

  // Character codes.
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  // Result of one sentence, apart from the comma count.
  typedef struct packed {
    logic       tag_match;
    logic       star_seen;
    logic [7:0] computed;
    logic [7:0] received;
    logic       checksum_ok;
    logic       sentence_valid;
  } nsc_result_t;

  // Digit value: codes above '9' lose 55, all others lose 48 (wraps mod 256).
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    return (c > CH_NINE) ? (c - HEX_ALPHA_OFS) : (c - CH_ZERO);
  endfunction

  // True for '0'..'9' and 'A'..'F'.
  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
  endfunction

endpackage

// ----- rtl/nsc_sentence.sv -----
// Sentence state machine: tag compare, running XOR, comma count and hex decode.
`timescale 1ns / 1ps

module nsc_sentence
  import nsc_pkg::*;
#(
  parameter int TAG_CHARS   = TAG_CHARS_DEF,
  parameter int COMMA_LIMIT = COMMA_LIMIT_DEF,
  localparam int TAG_W = 8 * TAG_CHARS,
  localparam int CNT_W = $clog2(COMMA_LIMIT + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [TAG_W-1:0] match_tag,
  output logic             res_valid,
  output nsc_result_t      res,
  output logic [CNT_W-1:0] res_commas
);

  localparam int POS_W = $clog2(TAG_CHARS + 1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX2 = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]       phase_r,    phase_nxt;
  logic [POS_W-1:0] tag_pos_r,  tag_pos_nxt;
  logic             tag_ok_r,   tag_ok_nxt;
  logic [7:0]       xor_r,      xor_nxt;
  logic [CNT_W-1:0] commas_r,   commas_nxt;
  logic             star_r,     star_nxt;
  logic [3:0]       hi_nib_r,   hi_nib_nxt;
  logic [1:0]       hex_good_r, hex_good_nxt;
  logic [7:0]       rcv_r,      rcv_nxt;

  logic [7:0] tag_byte;
  logic [7:0] digit;
  logic       tm;
  logic       ok;

  // Pick the expected tag character for the current position.
  always_comb begin
    tag_byte = '0;
    for (int i = 0; i < TAG_CHARS; i++) begin
      if (tag_pos_r == POS_W'(i)) begin
        tag_byte = match_tag[8*(TAG_CHARS-1-i) +: 8];
      end
    end
  end

  assign digit = hex_value(rx_byte);

  // Result fields as they stand when a carriage return arrives.
  assign tm = (phase_r != PH_IDLE) && tag_ok_r && (tag_pos_r >= POS_W'(TAG_CHARS));
  assign ok = star_r && (phase_r == PH_DONE) && (hex_good_r == 2'b11) && (rcv_r == xor_r);

  always_comb begin
    res.tag_match      = tm;
    res.star_seen      = star_r;
    res.computed       = xor_r;
    res.received       = rcv_r;
    res.checksum_ok    = ok;
    res.sentence_valid = tm && ok;
    res_commas         = commas_r;
  end

  // Next-state logic for one received character.
  always_comb begin
    phase_nxt    = phase_r;
    tag_pos_nxt  = tag_pos_r;
    tag_ok_nxt   = tag_ok_r;
    xor_nxt      = xor_r;
    commas_nxt   = commas_r;
    star_nxt     = star_r;
    hi_nib_nxt   = hi_nib_r;
    hex_good_nxt = hex_good_r;
    rcv_nxt      = rcv_r;
    res_valid    = 1'b0;
    if (step) begin
      if ((rx_byte == CH_CR) || (rx_byte == CH_DOLLAR)) begin
        // Both end the current sentence; a dollar opens a new one.
        res_valid    = (rx_byte == CH_CR);
        phase_nxt    = (rx_byte == CH_DOLLAR) ? PH_BODY : PH_IDLE;
        tag_ok_nxt   = (rx_byte == CH_DOLLAR);
        tag_pos_nxt  = '0;
        xor_nxt      = '0;
        commas_nxt   = '0;
        star_nxt     = 1'b0;
        hi_nib_nxt   = '0;
        hex_good_nxt = '0;
        rcv_nxt      = '0;
      end else begin
        unique case (phase_r)
          PH_BODY: begin
            if (rx_byte == CH_STAR) begin
              star_nxt  = 1'b1;
              phase_nxt = PH_HEX1;
            end else begin
              xor_nxt = xor_r ^ rx_byte;
              if ((rx_byte == CH_COMMA) && (commas_r < CNT_W'(COMMA_LIMIT))) begin
                commas_nxt = commas_r + 1'b1;
              end
              if (tag_pos_r < POS_W'(TAG_CHARS)) begin
                if (rx_byte != tag_byte) begin
                  tag_ok_nxt = 1'b0;
                end
                tag_pos_nxt = tag_pos_r + 1'b1;
              end
            end
          end
          PH_HEX1: begin
            hi_nib_nxt      = digit[3:0];
            rcv_nxt         = {digit[3:0], 4'h0};
            hex_good_nxt[0] = hex_good_r[0] | hex_ok(rx_byte);
            phase_nxt       = PH_HEX2;
          end
          PH_HEX2: begin
            rcv_nxt         = {hi_nib_r, 4'h0} + digit;
            hex_good_nxt[1] = hex_good_r[1] | hex_ok(rx_byte);
            phase_nxt       = PH_DONE;
          end
          default: begin
            // Idle and done ignore everything but dollar and carriage return.
          end
        endcase
      end
    end
  end

  // Sentence state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tag_pos_r  <= '0;
      tag_ok_r   <= 1'b0;
      xor_r      <= '0;
      commas_r   <= '0;
      star_r     <= 1'b0;
      hi_nib_r   <= '0;
      hex_good_r <= '0;
      rcv_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      tag_pos_r  <= tag_pos_nxt;
      tag_ok_r   <= tag_ok_nxt;
      xor_r      <= xor_nxt;
      commas_r   <= commas_nxt;
      star_r     <= star_nxt;
      hi_nib_r   <= hi_nib_nxt;
      hex_good_r <= hex_good_nxt;
      rcv_r      <= rcv_nxt;
    end
  end

endmodule

// ----- rtl/nmea_sentence_checker.sv -----
// Top level of the sentence checker: input stage, tag register, sentence core, result register.
//
//   channel  | direction | payload                                   | flow control
//   in_      | in        | in_rx_byte                                | in_valid / in_ready
//   out_     | out       | out_tag_match .. out_comma_count          | out_valid / out_ready
//   APB      | in/out    | match_tag at paddr 0 (64-bit data)        | pready tied high
//
// A character is held in the input register; the sentence logic between it and the
// state and result registers is combinational, so a carriage return's result is loaded
// into the result register as the carriage return leaves the input register.
// One character is taken every cycle; the only stall is a carriage return held in the
// input register while the previous result is still waiting for out_ready.
// Reset (synchronous, rst_n low) empties both registers, idles the sentence state
// and loads the tag register with "GPRMC".
`timescale 1ns / 1ps

module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int TAG_CHARS   = TAG_CHARS_DEF,
  parameter int COMMA_LIMIT = COMMA_LIMIT_DEF,
  localparam int TAG_W = 8 * TAG_CHARS,
  localparam int CNT_W = $clog2(COMMA_LIMIT + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input character channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_tag_match,
  output logic                  out_star_seen,
  output logic [7:0]            out_computed_checksum,
  output logic [7:0]            out_received_checksum,
  output logic                  out_checksum_ok,
  output logic                  out_sentence_valid,
  output logic [CNT_W-1:0]      out_comma_count,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "assert_macros.svh"

  logic [TAG_W-1:0]     tag_r;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_adv;
  logic                 in_fire;
  logic                 res_valid;
  nsc_result_t          res;
  logic [CNT_W-1:0]     res_commas;
  logic                 out_valid_r;
  nsc_result_t          out_res_r;
  logic [CNT_W-1:0]     out_commas_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  // Configuration register access.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_SLOT_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (psel) begin
      unique case (cfg_idx)
        REG_MATCH_TAG: prdata = CFG_DATA_W'(tag_r);
        default:       prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= TAG_RESET[TAG_W-1:0];
    end else if (cfg_wr && (cfg_idx == REG_MATCH_TAG)) begin
      tag_r <= pwdata[TAG_W-1:0];
    end
  end

  // Input stage: a carriage return waits here while the result register is full and out_ready is low.
  assign s1_adv   = s1_valid_r && !((s1_byte_r == CH_CR) && out_valid_r && !out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Sentence logic.
  nsc_sentence #(
    .TAG_CHARS   (TAG_CHARS),
    .COMMA_LIMIT (COMMA_LIMIT)
  ) u_sentence (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .rx_byte    (s1_byte_r),
    .match_tag  (tag_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_commas (res_commas)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r    <= res;
      out_commas_r <= res_commas;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_tag_match         = out_res_r.tag_match;
  assign out_star_seen         = out_res_r.star_seen;
  assign out_computed_checksum = out_res_r.computed;
  assign out_received_checksum = out_res_r.received;
  assign out_checksum_ok       = out_res_r.checksum_ok;
  assign out_sentence_valid    = out_res_r.sentence_valid;
  assign out_comma_count       = out_commas_r;

  // A carriage return leaving the input stage always lands a transaction in the result register.
  `NSC_ASSERT(a_cr_gives_result, (s1_adv && (s1_byte_r == CH_CR)) |=> out_valid_r, "carriage return produced no result")

  // The input side stalls only behind a carriage return blocked by a full result register.
  `NSC_ASSERT(a_stall_cause, !in_ready |-> (s1_valid_r && (s1_byte_r == CH_CR) && out_valid_r && !out_ready), "input stalled without cause")

  // A good checksum needs a star and matching received and computed values.
  `NSC_ASSERT(a_ok_consistent, (out_valid_r && out_checksum_ok) |-> (out_star_seen && (out_computed_checksum == out_received_checksum)), "checksum_ok without matching checksums")

endmodule
